// ===== hw/rtl/salru_pkg.sv =====
`default_nettype none
package salru_pkg;

	// Field widths of the access and result ports
	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 32;

	// Default cache geometry
	localparam int WAYS_DEF        = 2;
	localparam int BLOCK_BYTES_DEF = 64;
	localparam int CACHE_BYTES_DEF = 1 * 1024;
	localparam int ADDR_BITS_DEF   = 32;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;     // capture the address of a new transaction
		logic read;     // read the set row into the row registers
		logic resolve;  // compare, pick the way, write back, update counters
	} cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/salru_ctrl.sv =====
`default_nettype none
module salru_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	output logic                done,
	output salru_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_RESOLVE
	} state_t;

	state_t state_q;
	logic   done_q;

	// Advance through read and resolve for each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_RESOLVE);
			unique case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_READ;
				end
				ST_READ:    state_q <= ST_RESOLVE;
				ST_RESOLVE: state_q <= ST_IDLE;
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	// Decode commands from the current state
	always_comb begin
		cmd.load    = (state_q == ST_IDLE) && start;
		cmd.read    = (state_q == ST_READ);
		cmd.resolve = (state_q == ST_RESOLVE);
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule
`default_nettype wire

// ===== hw/rtl/salru_dp.sv =====
`default_nettype none
module salru_dp #(
	parameter int WAYS        = salru_pkg::WAYS_DEF,
	parameter int BLOCK_BYTES = salru_pkg::BLOCK_BYTES_DEF,
	parameter int CACHE_BYTES = salru_pkg::CACHE_BYTES_DEF,
	parameter int ADDR_BITS   = salru_pkg::ADDR_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire salru_pkg::cmd_t               cmd,
	input  wire logic [salru_pkg::ADDR_W-1:0]  address,
	output logic                               hit,
	output logic                               way_used,
	output logic                               evicted,
	output logic [salru_pkg::COUNT_W-1:0]      access_count,
	output logic [salru_pkg::COUNT_W-1:0]      miss_count
);

	localparam int AW       = salru_pkg::ADDR_W;
	localparam int CW       = salru_pkg::COUNT_W;
	localparam int NUM_SETS = CACHE_BYTES / (BLOCK_BYTES * WAYS);
	localparam int OFF_W    = $clog2(BLOCK_BYTES);
	localparam int SET_BITS = $clog2(NUM_SETS);
	localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int EFF_AW   = (ADDR_BITS < AW) ? ADDR_BITS : AW;
	localparam int TAG_BITS = EFF_AW - OFF_W - SET_BITS;
	localparam int TAG_W    = (TAG_BITS > 0) ? TAG_BITS : 1;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RANK_W   = WAY_W;
	localparam logic [AW-1:0] ADDR_MASK =
		(EFF_AW >= AW) ? {AW{1'b1}} : ((AW'(1) << EFF_AW) - AW'(1));
	localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(WAYS - 1);
	localparam logic [CW-1:0]     COUNT_MAX = {CW{1'b1}};

	typedef logic [WAYS-1:0][TAG_W-1:0]  tag_row_t;
	typedef logic [WAYS-1:0][RANK_W-1:0] rank_row_t;

	// Tag memory; valid bits and ranks are flops, valid bits cleared and ranks set to the way index at reset
	tag_row_t  tag_mem [NUM_SETS];
	logic [WAYS-1:0] valid_q [NUM_SETS];
	rank_row_t rank_q [NUM_SETS];

	logic [AW-1:0]    addr_q;
	logic [AW-1:0]    addr_eff;
	logic [AW-1:0]    addr_shift;
	logic [AW-1:0]    tag_full;
	logic [SET_W-1:0] set_idx;
	logic [TAG_W-1:0] tag;

	tag_row_t        row_tag_q;
	logic [WAYS-1:0] row_valid_q;
	rank_row_t       row_rank_q;

	logic [CW-1:0] acc_q;
	logic [CW-1:0] miss_q;

	logic             hit_c;
	logic             any_inv;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] inv_way;
	logic [WAY_W-1:0] lru_way;
	logic [WAY_W-1:0] way_c;
	logic             evict_c;
	logic [RANK_W-1:0] way_rank;
	rank_row_t        rank_new;
	logic [WAYS-1:0]  valid_new;
	tag_row_t         tag_new;
	logic [CW-1:0]    acc_next;
	logic [CW-1:0]    miss_next;

	// Split the address into set index and tag
	always_comb begin
		addr_eff   = address & ADDR_MASK;
		addr_shift = addr_q >> OFF_W;
		tag_full   = (addr_q & ADDR_MASK) >> (OFF_W + SET_BITS);
		set_idx    = (SET_BITS > 0) ? addr_shift[SET_W-1:0] : '0;
		tag        = tag_full[TAG_W-1:0];
	end

	// Hold the address of the transaction
	always_ff @(posedge clk) begin
		if (cmd.load) addr_q <= addr_eff;
	end

	// Read the tag row of the set and write back the updated row
	always_ff @(posedge clk) begin
		if (cmd.read) row_tag_q <= tag_mem[set_idx];
		if (cmd.resolve) tag_mem[set_idx] <= tag_new;
	end

	// Pick hit way, lowest invalid way and least recent way
	always_comb begin
		hit_c   = 1'b0;
		any_inv = 1'b0;
		hit_way = '0;
		inv_way = '0;
		lru_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row_valid_q[w] && (row_tag_q[w] == tag)) begin
				hit_c   = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!row_valid_q[w]) begin
				any_inv = 1'b1;
				inv_way = WAY_W'(w);
			end
			if (row_rank_q[w] == '0) lru_way = WAY_W'(w);
		end
		priority if (hit_c) way_c = hit_way;
		else if (any_inv)   way_c = inv_way;
		else                way_c = lru_way;
		evict_c = !hit_c && !any_inv;
	end

	// Build the updated row: ranks, valid bits and tags, and the next counter values
	always_comb begin
		way_rank  = row_rank_q[way_c];
		rank_new  = row_rank_q;
		valid_new = row_valid_q;
		tag_new   = row_tag_q;
		for (int v = 0; v < WAYS; v++) begin
			if (WAY_W'(v) == way_c) begin
				rank_new[v]  = RANK_TOP;
				valid_new[v] = 1'b1;
				if (!hit_c) tag_new[v] = tag;
			end else if (row_rank_q[v] > way_rank) begin
				rank_new[v] = row_rank_q[v] - RANK_W'(1);
			end
		end
		acc_next  = (acc_q == COUNT_MAX) ? acc_q : acc_q + CW'(1);
		miss_next = (hit_c || (miss_q == COUNT_MAX)) ? miss_q : miss_q + CW'(1);
	end

	// Reset and write back valid bits, ranks and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SETS; s++) begin
				valid_q[s] <= '0;
				for (int w = 0; w < WAYS; w++) begin
					rank_q[s][w] <= RANK_W'(w);
				end
			end
			acc_q  <= '0;
			miss_q <= '0;
		end else if (cmd.resolve) begin
			valid_q[set_idx] <= valid_new;
			rank_q[set_idx]  <= rank_new;
			acc_q            <= acc_next;
			miss_q           <= miss_next;
		end
	end

	// Capture the set row and the result fields
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			row_valid_q <= valid_q[set_idx];
			row_rank_q  <= rank_q[set_idx];
		end
		if (cmd.resolve) begin
			hit          <= hit_c;
			way_used     <= way_c[0];
			evicted      <= evict_c;
			access_count <= acc_next;
			miss_count   <= miss_next;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/set_assoc_cache_lru_tags_core.sv =====
// Tag store of a set-associative cache with true LRU replacement.
//
// Access channel: drive address and raise start; the transaction is taken
// at a rising edge where start is high and busy is low. busy stays high
// while the transaction is looked up and written back.
// Result channel: done is high for exactly one cycle with hit, way_used,
// evicted, access_count and miss_count valid in that cycle. The receiver
// cannot stall; the result fields hold until the next access is resolved.
// Sequence: the accepting edge captures the address, the set row is then read
// from the tag memory, and the compare and write back registers done with the
// results. A new access is taken only once the last one is through; the
// next start is taken in the cycle that done is shown. The tag memory has a
// single port, read then written once per access.
// Reset: arst_n low clears all valid bits, sets the recency rank of way w
// to w in every set and clears both counters; no clearing pass is run,
// so start is taken as soon as reset is released.
`default_nettype none
module set_assoc_cache_lru_tags_core #(
	parameter int WAYS        = salru_pkg::WAYS_DEF,
	parameter int BLOCK_BYTES = salru_pkg::BLOCK_BYTES_DEF,
	parameter int CACHE_BYTES = salru_pkg::CACHE_BYTES_DEF,
	parameter int ADDR_BITS   = salru_pkg::ADDR_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [salru_pkg::ADDR_W-1:0]  address,
	output logic                               done,
	output logic                               hit,
	output logic                               way_used,
	output logic                               evicted,
	output logic [salru_pkg::COUNT_W-1:0]      access_count,
	output logic [salru_pkg::COUNT_W-1:0]      miss_count
);

	salru_pkg::cmd_t cmd;

	// Sequence each transaction
	salru_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Tag lookup, replacement and counters
	salru_dp #(
		.WAYS        (WAYS),
		.BLOCK_BYTES (BLOCK_BYTES),
		.CACHE_BYTES (CACHE_BYTES),
		.ADDR_BITS   (ADDR_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.address      (address),
		.hit          (hit),
		.way_used     (way_used),
		.evicted      (evicted),
		.access_count (access_count),
		.miss_count   (miss_count)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/salru_chk.sv =====
`default_nettype none
module salru_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          done,
	input wire logic                          hit,
	input wire logic                          evicted,
	input wire logic [salru_pkg::COUNT_W-1:0] access_count,
	input wire logic [salru_pkg::COUNT_W-1:0] miss_count
);

	// Every accepted transaction gives a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result missing three cycles after accept");

	// The block is free again when a result is shown
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while result shown");

	// A hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> !evicted)
		else $error("eviction reported on hit");

	// Misses never outnumber accesses
	a_miss_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (miss_count <= access_count))
		else $error("miss count above access count");

	// A result without a prior transaction is invented
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !$past(busy)) |-> 1'b0)
		else $error("result without transaction in flight");

endmodule

bind set_assoc_cache_lru_tags_core salru_chk u_chk (.*);
`default_nettype wire
